// ----- sv/hmft_pkg.sv -----
// shared types, constants and fixed-point helpers of the harmonic mode force block
// used by hmft_front, hmft_back and the top level
package hmft_pkg;

    localparam int unsigned ATOMS_MAX_DEF = 65536;
    localparam int unsigned BEADS_MAX_DEF = 64;
    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam int unsigned IN_W          = 160;
    localparam int unsigned OUT_W         = 656;
    localparam int unsigned CNT_W         = 26;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [1:0] REG_FORCE_WEIGHT   = 2'd0;
    localparam logic [1:0] REG_ACTIVE_ATOMS   = 2'd1;
    localparam logic [1:0] REG_LOCAL_BEADS    = 2'd2;
    localparam logic [1:0] REG_THERMAL_ENERGY = 2'd3;

    typedef struct packed {
        logic [2:0][31:0] mag;    // position magnitudes
        logic [2:0]       rneg;   // position signs
        logic [31:0]      pre;
        logic [31:0]      eig;
        logic             last;
    } t_item;

    typedef struct packed {
        logic [31:0]      weight;
        logic [31:0]      kt;
        logic [CNT_W-1:0] cnt;    // 3 * atoms * beads
    } t_cfg;

    // (p >> sh) as a magnitude, saturated to a signed field of wd bits, sign applied
    function automatic logic [63:0] sat_scale(input logic [127:0] p, input logic [6:0] sh,
                                              input logic [6:0] wd, input logic ng);
        logic [127:0] q;
        logic [63:0]  maxpos;
        logic [63:0]  cap;
        logic [63:0]  m;
        q      = p >> sh;
        maxpos = (64'd1 << (wd - 7'd1)) - 64'd1;
        cap    = maxpos + {63'd0, ng};
        if (q[127:64] != 64'd0) begin
            m = cap;
        end else if (q[63:0] > cap) begin
            m = cap;
        end else begin
            m = q[63:0];
        end
        return ng ? (64'd0 - m) : m;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return a[63] ? (S64_MAX + 64'd1) : S64_MAX;
        end
        return s;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] d;
        d = a - b;
        if (a[63] != b[63] && d[63] != a[63]) begin
            return a[63] ? (S64_MAX + 64'd1) : S64_MAX;
        end
        return d;
    endfunction

    // position operand of tensor entry, order xx yy zz xy xz yz
    function automatic logic [1:0] tensor_ra(input logic [2:0] i);
        unique case (i)
            3'd0, 3'd3, 3'd4: return 2'd0;
            3'd1, 3'd5:       return 2'd1;
            default:          return 2'd2;
        endcase
    endfunction

    // force operand of tensor entry
    function automatic logic [1:0] tensor_fb(input logic [2:0] i);
        unique case (i)
            3'd0:       return 2'd0;
            3'd1, 3'd3: return 2'd1;
            default:    return 2'd2;
        endcase
    endfunction

endpackage

// ----- sv/hmft_front.sv -----
// front end: takes input requests, splits positions into sign and magnitude
// and holds them in a short queue; uses hmft_pkg
module hmft_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [hmft_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                       s_axis_tlast,
    output logic                       o_q_valid,
    input  logic                       i_q_pop,
    output hmft_pkg::t_item            o_q_item
);
    localparam int unsigned PW = $clog2(hmft_pkg::QUEUE_DEPTH);

    hmft_pkg::t_item r_mem [hmft_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_head;
    logic [PW-1:0]   r_tail;
    logic [PW:0]     r_count;
    hmft_pkg::t_item w_item;
    logic            w_push;
    logic            w_pop;

    always_comb begin
        w_item = '0;
        for (int k = 0; k < 3; k++) begin
            w_item.rneg[k] = s_axis_tdata[32*k+31];
            w_item.mag[k]  = s_axis_tdata[32*k+31] ? (32'd0 - s_axis_tdata[32*k +: 32])
                                                   : s_axis_tdata[32*k +: 32];
        end
        w_item.pre  = s_axis_tdata[127:96];
        w_item.eig  = s_axis_tdata[159:128];
        w_item.last = s_axis_tlast;
    end

    assign s_axis_tready = (r_count != (PW+1)'(hmft_pkg::QUEUE_DEPTH));
    assign o_q_valid     = (r_count != '0);
    assign o_q_item      = r_mem[r_head];
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign w_pop         = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_tail <= r_tail + PW'(1);
            end
            if (w_pop) begin
                r_head <= r_head + PW'(1);
            end
            r_count <= r_count + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end
endmodule

// ----- sv/hmft_mul.sv -----
// 64 x 64 bit unsigned multiplier built from one 32 x 32 unit, one partial
// product per cycle into a 128 bit accumulator; no package use
module hmft_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic [127:0]  o_p,
    output logic          o_done
);
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [1:0]   r_k;
    logic         r_busy;
    logic [63:0]  r_pp;
    logic [1:0]   r_psh;
    logic         r_plast;
    logic         r_ppv;
    logic [127:0] r_acc;
    logic         r_done;
    logic [31:0]  w_al;
    logic [31:0]  w_bl;
    logic [7:0]   w_shift;

    assign w_al    = r_k[1] ? r_a[63:32] : r_a[31:0];
    assign w_bl    = r_k[0] ? r_b[63:32] : r_b[31:0];
    assign w_shift = 8'({1'b0, r_psh[1]} + {1'b0, r_psh[0]}) << 5;
    assign o_p     = r_acc;
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            r_ppv  <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_k    <= '0;
                r_busy <= 1'b1;
                r_acc  <= '0;
            end else begin
                if (r_busy) begin
                    r_pp    <= w_al * w_bl;
                    r_psh   <= r_k;
                    r_plast <= (r_k == 2'd3);
                    r_ppv   <= 1'b1;
                    r_k     <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_busy <= 1'b0;
                    end
                end
                if (r_ppv) begin
                    r_acc <= r_acc + ({64'd0, r_pp} << w_shift);
                    if (r_plast) begin
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end
endmodule

// ----- sv/hmft_back.sv -----
// back end: sequences the force, energy and tensor arithmetic over the shared
// multiplier and drives the result register; uses hmft_pkg and hmft_mul
module hmft_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    output logic                       o_q_pop,
    input  hmft_pkg::t_item            i_q_item,
    input  hmft_pkg::t_cfg             i_cfg,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [hmft_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                       m_axis_tlast
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_OUT} t_state;
    typedef enum logic [2:0] {OP_FK, OP_FU, OP_FW, OP_SQ, OP_E, OP_T, OP_W, OP_B} t_op;

    t_state          r_state;
    t_op             r_op;
    logic [2:0]      r_i;
    hmft_pkg::t_item r_item;
    logic [47:0]     r_fk;
    logic [2:0][47:0] r_fu_mag;
    logic [2:0]      r_fu_neg;
    logic [63:0]     r_r2;
    logic [2:0][47:0] r_force;
    logic [63:0]     r_energy;
    logic [5:0][63:0] r_tsum;
    logic [5:0][63:0] r_tout;
    logic [63:0]     r_prim;
    logic            r_ov;
    logic [hmft_pkg::OUT_W-1:0] r_odata;
    logic            r_olast;

    t_op             n_op;
    logic [2:0]      n_i;
    logic            n_fin;
    logic [1:0]      w_ix;
    logic [1:0]      w_ra;
    logic [1:0]      w_fb;
    logic [63:0]     w_a;
    logic [63:0]     w_b;
    logic [127:0]    w_p;
    logic            w_done;
    logic [6:0]      w_sh;
    logic [6:0]      w_wd;
    logic            w_ng;
    logic [63:0]     w_scl;
    logic [63:0]     w_base;

    assign w_ix = r_i[1:0];
    assign w_ra = hmft_pkg::tensor_ra(r_i);
    assign w_fb = hmft_pkg::tensor_fb(r_i);

    hmft_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_RUN),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_p     (w_p),
        .o_done  (w_done)
    );

    always_comb begin
        w_a  = '0;
        w_b  = '0;
        w_sh = 7'd0;
        w_wd = 7'd64;
        w_ng = 1'b0;
        unique case (r_op)
            OP_FK: begin
                w_a = {32'd0, r_item.pre};
                w_b = {32'd0, r_item.eig};
            end
            OP_FU: begin
                w_a  = {16'd0, r_fk};
                w_b  = {32'd0, r_item.mag[w_ix]};
                w_sh = 7'd19;
                w_wd = 7'd48;
                w_ng = !r_item.rneg[w_ix];
            end
            OP_FW: begin
                w_a  = {16'd0, r_fu_mag[w_ix]};
                w_b  = {32'd0, i_cfg.weight};
                w_sh = 7'd16;
                w_wd = 7'd48;
                w_ng = r_fu_neg[w_ix];
            end
            OP_SQ: begin
                w_a = {32'd0, r_item.mag[w_ix]};
                w_b = {32'd0, r_item.mag[w_ix]};
            end
            OP_E: begin
                w_a  = {16'd0, r_fk};
                w_b  = r_r2;
                w_sh = 7'd40;
            end
            OP_T: begin
                w_a  = {32'd0, r_item.mag[w_ra]};
                w_b  = {16'd0, r_fu_mag[w_fb]};
                w_sh = 7'd20;
                w_ng = r_item.rneg[w_ra] ^ r_fu_neg[w_fb];
            end
            OP_W: begin
                w_a  = r_tsum[r_i][63] ? (64'd0 - r_tsum[r_i]) : r_tsum[r_i];
                w_b  = {32'd0, i_cfg.weight};
                w_sh = 7'd16;
                w_ng = r_tsum[r_i][63];
            end
            OP_B: begin
                w_a = {(64-hmft_pkg::CNT_W)'(0), i_cfg.cnt};
                w_b = {32'd0, i_cfg.kt};
            end
            default: ;
        endcase
    end

    assign w_scl  = hmft_pkg::sat_scale(w_p, w_sh, w_wd, w_ng);
    // kinetic term goes to Q32.32 by a shift of 15
    assign w_base = (w_p[127:64] != 64'd0 || w_p[63:0] > 64'h0000_FFFF_FFFF_FFFF)
                  ? hmft_pkg::S64_MAX : {w_p[48:0], 15'd0};

    always_comb begin
        n_op  = r_op;
        n_i   = 3'd0;
        n_fin = 1'b0;
        unique case (r_op)
            OP_FK: n_op = OP_FU;
            OP_FU: begin
                if (r_i == 3'd2) n_op = OP_FW;
                else n_i = r_i + 3'd1;
            end
            OP_FW: begin
                if (r_i == 3'd2) n_op = OP_SQ;
                else n_i = r_i + 3'd1;
            end
            OP_SQ: begin
                if (r_i == 3'd2) n_op = OP_E;
                else n_i = r_i + 3'd1;
            end
            OP_E: n_op = OP_T;
            OP_T: begin
                if (r_i != 3'd5) n_i = r_i + 3'd1;
                else if (r_item.last) n_op = OP_W;
                else n_fin = 1'b1;
            end
            OP_W: begin
                if (r_i == 3'd5) n_op = OP_B;
                else n_i = r_i + 3'd1;
            end
            OP_B: n_fin = 1'b1;
            default: ;
        endcase
    end

    assign o_q_pop       = (r_state == S_IDLE) && i_q_valid;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_FK;
            r_i      <= '0;
            r_ov     <= 1'b0;
            r_energy <= '0;
            r_tsum   <= '0;
        end else begin
            if (r_ov && m_axis_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_item;
                        r_r2    <= '0;
                        r_op    <= OP_FK;
                        r_i     <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_done) begin
                        unique case (r_op)
                            OP_FK: r_fk <= w_p[63:16];
                            OP_FU: begin
                                r_fu_neg[w_ix] <= w_scl[47];
                                r_fu_mag[w_ix] <= w_scl[47] ? (48'd0 - w_scl[47:0])
                                                            : w_scl[47:0];
                            end
                            OP_FW: r_force[w_ix] <= w_scl[47:0];
                            OP_SQ: r_r2 <= r_r2 + w_p[63:0];
                            OP_E:  r_energy <= hmft_pkg::sat_add(r_energy, w_scl);
                            OP_T:  r_tsum[r_i] <= hmft_pkg::sat_add(r_tsum[r_i], w_scl);
                            OP_W:  r_tout[r_i] <= w_scl;
                            OP_B:  r_prim <= hmft_pkg::sat_sub(w_base, r_energy);
                            default: ;
                        endcase
                        r_op    <= n_op;
                        r_i     <= n_i;
                        r_state <= n_fin ? S_OUT : S_RUN;
                    end
                end
                S_OUT: begin
                    if (!r_ov || m_axis_tready) begin
                        r_ov    <= 1'b1;
                        r_olast <= r_item.last;
                        r_odata <= {r_item.last ? r_prim : 64'd0,
                                    r_energy,
                                    r_item.last ? r_tout : 384'd0,
                                    r_force};
                        if (r_item.last) begin
                            r_energy <= '0;
                            r_tsum   <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/harmonic_mode_force_and_tensor_top.sv -----
// top level of the harmonic mode force and tensor block: configuration
// registers, front queue and arithmetic back end; uses hmft_pkg
//
// channel    dir  signals                                   contents
// s_axis     in   s_axis_tvalid/tready/tdata[159:0]/tlast   one atom of one bead
// m_axis     out  m_axis_tvalid/tready/tdata[655:0]/tlast   force, energy, frame totals
// cfg        in   i_cfg_we/i_cfg_idx[1:0]/i_cfg_data[31:0]  register writes
//
// each item runs 17 multiplies, 24 on a frame end, through one 32 x 32 bit
// multiplier that builds each 64 x 64 product in four partial products.
// the front queue holds four items and accepts while the back end works.
// reset is synchronous active low and clears the queue, accumulators and registers.
// a stalled result waits in the output register and holds up the back end; the queue still accepts until full.
module harmonic_mode_force_and_tensor_top #(
    parameter int unsigned ATOMS_MAX = hmft_pkg::ATOMS_MAX_DEF,
    parameter int unsigned BEADS_MAX = hmft_pkg::BEADS_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // pos_x, pos_y, pos_z, spring_prefactor, mode_eigenvalue
    input  logic [hmft_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // force_x, force_y, force_z, tensor_xx, tensor_yy, tensor_zz, tensor_xy,
    // tensor_xz, tensor_yz, harmonic_energy, primitive_energy
    output logic [hmft_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                       m_axis_tlast,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [31:0]                i_cfg_data
);
    localparam logic [20:0] AMAX = 21'(ATOMS_MAX);
    localparam logic [10:0] BMAX = 11'(BEADS_MAX);

    logic [31:0]     r_force_weight;
    logic [16:0]     r_active_atoms;
    logic [6:0]      r_local_beads;
    logic [31:0]     r_thermal_energy;
    logic [16:0]     w_atoms;
    logic [6:0]      w_beads;
    logic [23:0]     w_ab;
    hmft_pkg::t_cfg  w_cfg;
    logic            w_q_valid;
    logic            w_q_pop;
    hmft_pkg::t_item w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force_weight   <= 32'd65536;
            r_active_atoms   <= 17'd0;
            r_local_beads    <= 7'd1;
            r_thermal_energy <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hmft_pkg::REG_FORCE_WEIGHT:   r_force_weight   <= i_cfg_data;
                hmft_pkg::REG_ACTIVE_ATOMS:   r_active_atoms   <= i_cfg_data[16:0];
                hmft_pkg::REG_LOCAL_BEADS:    r_local_beads    <= i_cfg_data[6:0];
                hmft_pkg::REG_THERMAL_ENERGY: r_thermal_energy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_atoms = ({4'd0, r_active_atoms} > AMAX) ? AMAX[16:0] : r_active_atoms;
    assign w_beads = ({4'd0, r_local_beads} > BMAX) ? BMAX[6:0] : r_local_beads;
    assign w_ab    = w_atoms * w_beads;

    always_comb begin
        w_cfg.weight = r_force_weight;
        w_cfg.kt     = r_thermal_energy;
        w_cfg.cnt    = {2'd0, w_ab} + {1'b0, w_ab, 1'b0};
    end

    hmft_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_q_valid     (w_q_valid),
        .i_q_pop       (w_q_pop),
        .o_q_item      (w_q_item)
    );

    hmft_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .o_q_pop       (w_q_pop),
        .i_q_item      (w_q_item),
        .i_cfg         (w_cfg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // frame totals are zero on results that do not close a frame
    a_totals_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            m_axis_tdata[527:144] == 384'd0 && m_axis_tdata[655:592] == 64'd0)
        else $error("frame totals set on an item that is not a frame end");

    // a full queue must hold something for the back end
    a_full_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_q_valid)
        else $error("input stalled with empty queue");

    // nothing is pending in the first cycle after reset
    a_reset_clear: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid && !w_q_valid)
        else $error("state survived reset");

    // the back end pops only what the queue offers
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("pop from empty queue");
endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench of harmonic_mode_force_and_tensor_top: directed table, then random
// frames under several register settings, checked against a predictor; uses hmft_pkg
module tb_top;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] pre;
        logic [31:0] eig;
        logic        last;
        logic        zero_force;   // forces known to be zero
    } t_atom_req;

    typedef struct packed {
        logic [2:0][47:0] frc;
        logic [5:0][63:0] tens;    // xx yy zz xy xz yz
        logic [63:0]      energy;
        logic [63:0]      prim;
        logic             done;
    } t_frame_res;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [hmft_pkg::IN_W-1:0]    s_axis_tdata = '0;
    logic                         s_axis_tlast = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [hmft_pkg::OUT_W-1:0]   m_axis_tdata;
    logic                         m_axis_tlast;
    logic                         i_cfg_we = 1'b0;
    logic [1:0]                   i_cfg_idx = '0;
    logic [31:0]                  i_cfg_data = '0;

    // predictor state
    logic [31:0] wt_q = 32'd65536;
    logic [16:0] atoms_q = '0;
    logic [6:0]  beads_q = 7'd1;
    logic [31:0] kt_q = '0;
    logic [63:0] energy_acc = '0;
    logic [5:0][63:0] tensor_acc = '0;

    t_frame_res expected_results[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  frames_seen = 0;
    int  items_sent = 0;
    bit  steady = 1'b0;         // no idling on either side
    int  rx_stall = 0;

    harmonic_mode_force_and_tensor_top u_top (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // (a*b) >> sh on magnitudes, saturated to a signed field of wd bits
    function automatic logic [63:0] mul_shift_sat(input bit ng, input logic [63:0] a,
                                                  input logic [63:0] b, input int sh,
                                                  input int wd);
        logic [127:0] p;
        logic [63:0]  cap;
        logic [63:0]  m;
        p   = ({64'd0, a} * {64'd0, b}) >> sh;
        cap = ((64'd1 << (wd - 1)) - 64'd1) + {63'd0, ng};
        m   = (p[127:64] != 0 || p[63:0] > cap) ? cap : p[63:0];
        return ng ? (64'd0 - m) : m;
    endfunction

    function automatic logic [63:0] add_clamp(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s;
    endfunction

    function automatic logic [63:0] sub_clamp(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] d;
        d = a - b;
        if (a[63] != b[63] && d[63] != a[63])
            return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return d;
    endfunction

    function automatic t_frame_res predict_harmonic(input t_atom_req it);
        t_frame_res   res;
        logic [63:0]  r [3];
        logic [63:0]  fu [3];
        logic [63:0]  fk, r2, m, e, t, base, atoms, beads;
        logic [127:0] kin;
        int ra [6] = '{0, 1, 2, 0, 0, 1};
        int fb [6] = '{0, 1, 2, 1, 2, 2};
        res = '0;
        r[0] = {{32{it.x[31]}}, it.x};
        r[1] = {{32{it.y[31]}}, it.y};
        r[2] = {{32{it.z[31]}}, it.z};
        fk = ({32'd0, it.pre} * {32'd0, it.eig}) >> 16;
        r2 = '0;
        for (int i = 0; i < 3; i++) begin
            m = mag64(r[i]);
            r2 += m * m;
            // force opposes the displacement
            fu[i] = mul_shift_sat(!r[i][63], fk, m, 19, 48);
            res.frc[i] = mul_shift_sat(fu[i][63], mag64(fu[i]), {32'd0, wt_q}, 16, 48);
        end
        e = mul_shift_sat(1'b0, fk, r2, 40, 64);
        energy_acc = add_clamp(energy_acc, e);
        for (int i = 0; i < 6; i++) begin
            t = mul_shift_sat(r[ra[i]][63] != fu[fb[i]][63], mag64(r[ra[i]]),
                              mag64(fu[fb[i]]), 20, 64);
            tensor_acc[i] = add_clamp(tensor_acc[i], t);
        end
        res.energy = energy_acc;
        if (it.last) begin
            atoms = (atoms_q > 17'd65536) ? 64'd65536 : {47'd0, atoms_q};
            beads = (beads_q > 7'd64) ? 64'd64 : {57'd0, beads_q};
            for (int i = 0; i < 6; i++)
                res.tens[i] = mul_shift_sat(tensor_acc[i][63], mag64(tensor_acc[i]),
                                            {32'd0, wt_q}, 16, 64);
            kin  = {64'd0, 64'd3 * atoms * beads} * {96'd0, kt_q};
            base = (kin > 128'h0000_FFFF_FFFF_FFFF) ? {1'b0, {63{1'b1}}}
                                                     : (kin[63:0] << 15);
            res.prim = sub_clamp(base, energy_acc);
            res.done = 1'b1;
            energy_acc = '0;
            tensor_acc = '0;
        end
        if (it.zero_force) res.frc = '0;
        return res;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            hmft_pkg::REG_FORCE_WEIGHT:   wt_q    = val;
            hmft_pkg::REG_ACTIVE_ATOMS:   atoms_q = val[16:0];
            hmft_pkg::REG_LOCAL_BEADS:    beads_q = val[6:0];
            hmft_pkg::REG_THERMAL_ENERGY: kt_q    = val;
            default: ;
        endcase
    endtask

    task automatic send_atom(input t_atom_req it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.eig, it.pre, it.z, it.y, it.x};
        s_axis_tlast  <= it.last;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(predict_harmonic(it));
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_pos();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = $urandom;
            1:       v = $urandom_range(0, 32'h00FF_FFFF);
            2:       v = 32'd0 - $urandom_range(0, 32'h00FF_FFFF);
            default: v = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_coef();
        return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0400_0000);
    endfunction

    task automatic random_frames(input int n_items);
        t_atom_req it;
        int left;
        left = 0;
        for (int k = 0; k < n_items; k++) begin
            if (left == 0) left = $urandom_range(1, 8);
            left--;
            it.x = rand_pos();
            it.y = rand_pos();
            it.z = rand_pos();
            it.pre = rand_coef();
            it.eig = rand_coef();
            it.last = (left == 0) || (k == n_items - 1);
            it.zero_force = 1'b0;
            if (k % 60 == 0) steady = ($urandom_range(0, 3) == 0);
            send_atom(it);
            if (it.last) left = 0;
        end
        steady = 1'b0;
    endtask

    // receiver: random stall before each result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_stall = steady ? 0 : $urandom_range(0, 14);
            m_axis_tready <= (rx_stall == 0);
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= (rx_stall == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s on result %0d: expected %h, got %h",
                         name, results_seen, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_res ex;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with no request outstanding");
            end else begin
                ex = expected_results.pop_front();
                for (int i = 0; i < 3; i++)
                    check_field($sformatf("force[%0d]", i), {16'd0, ex.frc[i]},
                                {16'd0, m_axis_tdata[48*i +: 48]});
                for (int i = 0; i < 6; i++)
                    check_field($sformatf("tensor[%0d]", i), ex.tens[i],
                                m_axis_tdata[144 + 64*i +: 64]);
                check_field("harmonic_energy", ex.energy, m_axis_tdata[528 +: 64]);
                check_field("primitive_energy", ex.prim, m_axis_tdata[592 +: 64]);
                check_field("frame_done", {63'd0, ex.done}, {63'd0, m_axis_tlast});
                if (ex.done) frames_seen++;
            end
            results_seen++;
        end
    end

    // directed rows: extremes of positions and coefficients, frame ends
    t_atom_req directed [16] = '{
        '{32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b0, 1'b0},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b1, 1'b0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1},
        '{32'h0010_0000, 32'hFFF0_0000, 32'h0020_0000, 32'h0100_0000, 32'h0100_0000,
          1'b0, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'h0100_0000, 32'h0300_0000,
          1'b0, 1'b0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
          1'b1, 1'b0},
        '{32'h0010_0000, 32'd0, 32'd0, 32'h0100_0000, 32'h0100_0000, 1'b1, 1'b0},
        '{32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 32'h0000_0001, 32'h0000_0001,
          1'b0, 1'b0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b0, 1'b0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b1, 1'b0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1000_0000, 32'h2000_0000,
          1'b0, 1'b0},
        '{32'hFFF0_0000, 32'hFFF0_0000, 32'hFFF0_0000, 32'h0080_0000, 32'h0200_0000,
          1'b1, 1'b0},
        '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1},
        '{32'h0000_0400, 32'hFFFF_FC00, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
          1'b0, 1'b0},
        '{32'h0040_0000, 32'h0040_0000, 32'h0040_0000, 32'h0200_0000, 32'h0100_0000,
          1'b1, 1'b0}
    };

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of all registers
        foreach (directed[i]) send_atom(directed[i]);
        drain_results();

        // top extremes, out-of-range atoms and beads saturate
        write_reg(hmft_pkg::REG_FORCE_WEIGHT, 32'hFFFF_FFFF);
        write_reg(hmft_pkg::REG_ACTIVE_ATOMS, 32'hFFFF_FFFF);
        write_reg(hmft_pkg::REG_LOCAL_BEADS, 32'hFFFF_FFFF);
        write_reg(hmft_pkg::REG_THERMAL_ENERGY, 32'hFFFF_FFFF);
        foreach (directed[i]) send_atom(directed[i]);
        random_frames(40);
        drain_results();

        // bottom extremes: no weight, no kinetic term
        write_reg(hmft_pkg::REG_FORCE_WEIGHT, 32'd0);
        write_reg(hmft_pkg::REG_ACTIVE_ATOMS, 32'd0);
        write_reg(hmft_pkg::REG_LOCAL_BEADS, 32'd0);
        write_reg(hmft_pkg::REG_THERMAL_ENERGY, 32'd0);
        random_frames(40);
        drain_results();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(hmft_pkg::REG_FORCE_WEIGHT,
                      $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0002_0000));
            write_reg(hmft_pkg::REG_ACTIVE_ATOMS,
                      $urandom_range(0, 3) == 0 ? 32'd65536 : $urandom_range(0, 32'h1_FFFF));
            write_reg(hmft_pkg::REG_LOCAL_BEADS, $urandom_range(0, 127));
            write_reg(hmft_pkg::REG_THERMAL_ENERGY, $urandom);
            random_frames(70);
            // in the third setting the sender holds off until every outstanding request has its result
            if (ph == 2) begin
                s_axis_tvalid <= 1'b0;
                while (expected_results.size() != 0) @(posedge i_clk);
            end
            random_frames(70);
            drain_results();
        end

        $display("%0d requests in %0d frames, %0d results checked over nine settings",
                 items_sent, frames_seen, results_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("harmonic_mode_force_and_tensor_top regression: pass");
        else
            $display("harmonic_mode_force_and_tensor_top regression: fail");
        $finish;
    end

    initial begin
        #40000000;
        $display("harmonic_mode_force_and_tensor_top regression: fail");
        $finish;
    end

endmodule
